@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that must also hold while reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/lfpd_pkg.sv @@
package lfpd_pkg;

  // Default block parameters
  localparam int unsigned POINTS_PER_FRAME_DEF = 20;
  localparam int unsigned REV_STORE_POINTS_DEF = 250;
  localparam int unsigned FRAMES_PER_REV_DEF   = 14;
  localparam int unsigned POINTS_PER_FRAME_MAX = 40;

  // Frame layout
  localparam int unsigned HDR_BYTES        = 4;
  localparam int unsigned SAMPLE_SHIFT     = 2;
  localparam int unsigned BYTES_PER_SAMPLE = 1 << SAMPLE_SHIFT;
  localparam int unsigned ANGLE_LO_POS     = 2;
  localparam int unsigned ANGLE_HI_POS     = 3;
  localparam logic [1:0]  DIST_LO_OFS      = 2'd0;
  localparam logic [1:0]  DIST_HI_OFS      = 2'd1;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ANGLE_IN_W = 15;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned SLOT_OUT_W = 9;
  localparam int unsigned IDX_W      = $clog2(POINTS_PER_FRAME_MAX);

  // Angle arithmetic: 1/64 deg input, 1/1280 deg interpolation
  localparam int unsigned FULL_TURN_COARSE = 23040;
  localparam int unsigned ANGLE_SCALE      = 20;
  localparam int unsigned BASE_W           = ANGLE_IN_W + 5;
  localparam int unsigned PROD_W           = STEP_W + IDX_W + 1;
  localparam int unsigned X_W              = 24;
  localparam logic signed [X_W-1:0] FULL_TURN_FINE = 24'sd460800;
  // centidegrees = floor(x * 5 / 64)
  localparam int unsigned FRAC_SHIFT       = 6;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Point request from front to back
  typedef struct packed {
    logic [ANGLE_IN_W-1:0] start_angle;
    logic [STEP_W-1:0]     step;
    logic [IDX_W-1:0]      idx;
    logic [DIST_W-1:0]     distance;
  } point_req_t;

  // Per-point fields carried down the back pipeline
  typedef struct packed {
    logic [DIST_W-1:0]     distance;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  beyond_store;
    logic                  last_of_frame;
    logic                  end_of_revolution;
  } point_meta_t;

endpackage

@@ hw/rtl/lfpd_front.sv @@
`include "assert_macros.svh"

module lfpd_front #(
  parameter int unsigned POINTS_PER_FRAME = lfpd_pkg::POINTS_PER_FRAME_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             rx_byte_i,
  input  logic                   frame_start_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output lfpd_pkg::point_req_t   req_o
);
  import lfpd_pkg::*;

  localparam int unsigned FrameBytes = HDR_BYTES + BYTES_PER_SAMPLE * POINTS_PER_FRAME;
  localparam int unsigned PosW       = $clog2(FrameBytes + 1);

  logic [PosW-1:0]       pos_q, pos_d, pos_cur, pos_ofs;
  logic [ANGLE_IN_W-1:0] prev_q, prev_d, cur_q, cur_d, new_angle;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [BYTE_W-1:0]     dist_lo_q, dist_lo_d;
  logic [STEP_W:0]       diff_wide;
  logic                  accept, in_samples;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Byte position; a frame start forces byte 0
  assign pos_cur    = frame_start_i ? '0 : pos_q;
  assign pos_ofs    = pos_cur - PosW'(HDR_BYTES);
  assign in_samples = (pos_cur >= PosW'(HDR_BYTES)) && (pos_cur < PosW'(FrameBytes));

  // Start angle and wrapped difference to the previous one
  assign new_angle = {rx_byte_i[6:0], cur_q[7:0]};
  assign diff_wide = {2'b00, new_angle}
                   + ((new_angle > prev_q) ? '0 : (STEP_W+1)'(FULL_TURN_COARSE))
                   - {2'b00, prev_q};

  always_comb begin
    pos_d     = pos_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    step_d    = step_q;
    dist_lo_d = dist_lo_q;
    push_o    = 1'b0;
    if (accept) begin
      pos_d = (pos_cur < PosW'(FrameBytes)) ? pos_cur + 1'b1 : PosW'(FrameBytes);
      if (pos_cur == PosW'(ANGLE_LO_POS)) begin
        cur_d = ANGLE_IN_W'(rx_byte_i);
      end else if (pos_cur == PosW'(ANGLE_HI_POS)) begin
        step_d = diff_wide[STEP_W-1:0];
        prev_d = new_angle;
        cur_d  = new_angle;
      end else if (in_samples) begin
        if (pos_ofs[1:0] == DIST_LO_OFS) begin
          dist_lo_d = rx_byte_i;
        end else if (pos_ofs[1:0] == DIST_HI_OFS) begin
          push_o = 1'b1;
        end
      end
    end
  end

  // Request fields, valid with push_o
  assign req_o.start_angle = cur_q;
  assign req_o.step        = step_q;
  assign req_o.idx         = IDX_W'(pos_ofs >> SAMPLE_SHIFT);
  assign req_o.distance    = {rx_byte_i, dist_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      prev_q    <= '0;
      cur_q     <= '0;
      step_q    <= '0;
      dist_lo_q <= '0;
    end else begin
      pos_q     <= pos_d;
      prev_q    <= prev_d;
      cur_q     <= cur_d;
      step_q    <= step_d;
      dist_lo_q <= dist_lo_d;
    end
  end

  `ASSERT_RST(a_pos_bound, pos_q <= PosW'(FrameBytes), "byte position past frame end")
  `ASSERT_RST(a_push_on_accept, push_o |-> (in_valid_i && !q_full_i), "push without accept")
  `ASSERT_RST(a_push_idx, push_o |-> (req_o.idx < IDX_W'(POINTS_PER_FRAME)),
              "sample index out of range")

endmodule

@@ hw/rtl/lfpd_queue.sv @@
`include "assert_macros.svh"

module lfpd_queue #(
  parameter int unsigned DEPTH = lfpd_pkg::QUEUE_DEPTH,
  parameter int unsigned WIDTH = $bits(lfpd_pkg::point_req_t)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);
  import lfpd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping with wrap at DEPTH
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_RST(a_count_bound, count_q <= CntW'(DEPTH), "queue overfilled")
  `ASSERT_RST(a_no_drop, push_i |-> !full_o, "push into full queue")
  `ASSERT_RST(a_fill_step, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1),
              "fill count out of step")

endmodule

@@ hw/rtl/lfpd_back.sv @@
`include "assert_macros.svh"

module lfpd_back #(
  parameter int unsigned POINTS_PER_FRAME = lfpd_pkg::POINTS_PER_FRAME_DEF,
  parameter int unsigned REV_STORE_POINTS = lfpd_pkg::REV_STORE_POINTS_DEF,
  parameter int unsigned FRAMES_PER_REV   = lfpd_pkg::FRAMES_PER_REV_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  lfpd_pkg::point_req_t  req_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           angle_centideg_o,
  output logic [15:0]           distance_o,
  output logic [8:0]            slot_index_o,
  output logic                  beyond_store_o,
  output logic                  last_of_frame_o,
  output logic                  end_of_revolution_o
);
  import lfpd_pkg::*;

  localparam int unsigned RevPoints = FRAMES_PER_REV * POINTS_PER_FRAME;
  localparam int unsigned SbW       = $clog2(RevPoints + 1);

  logic                     s1_valid_q, s2_valid_q, out_valid_q;
  logic                     s1_ready, s2_ready, out_ready;
  logic signed [PROD_W-1:0] step_ext, idx_ext, prod_q;
  logic [BASE_W-1:0]        base_q;
  point_meta_t              s1_meta_q, s1_meta_d, s2_meta_q, out_meta_q;
  logic signed [X_W-1:0]    x_sum, x_wrap, x_q;
  logic signed [X_W+2:0]    y_scaled;
  logic [ANGLE_W-1:0]       angle_q;
  logic [SbW-1:0]           slot_base_q, slot_base_d, slot, next_base;
  logic                     last, eor;

  // Pipeline flow control
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign pop_o     = q_valid_i && s1_ready;

  // Slot bookkeeping, taken in queue order
  assign slot      = slot_base_q + SbW'(req_i.idx);
  assign next_base = slot_base_q + SbW'(POINTS_PER_FRAME);
  assign last      = (req_i.idx == IDX_W'(POINTS_PER_FRAME - 1));
  assign eor       = last && (next_base >= SbW'(RevPoints));

  always_comb begin
    slot_base_d = slot_base_q;
    if (pop_o && last) begin
      slot_base_d = eor ? '0 : next_base;
    end
  end

  assign s1_meta_d.distance          = req_i.distance;
  assign s1_meta_d.slot_index        = SLOT_OUT_W'(slot);
  assign s1_meta_d.beyond_store      = (32'(slot) >= 32'(REV_STORE_POINTS));
  assign s1_meta_d.last_of_frame     = last;
  assign s1_meta_d.end_of_revolution = eor;

  // Stage 1 operands: step times sample index
  assign step_ext = PROD_W'($signed(req_i.step));
  assign idx_ext  = $signed({{(PROD_W-IDX_W){1'b0}}, req_i.idx});

  // Stage 2: fine angle with wrap past a full turn
  assign x_sum  = $signed({{(X_W-BASE_W){1'b0}}, base_q}) + X_W'(prod_q);
  assign x_wrap = (x_sum > FULL_TURN_FINE) ? x_sum - FULL_TURN_FINE : x_sum;

  // Output stage: x * 5, floor by 64
  assign y_scaled = ((X_W+3)'(x_q) <<< 2) + (X_W+3)'(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      slot_base_q <= '0;
    end else begin
      slot_base_q <= slot_base_d;
      if (s1_ready) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q    <= step_ext * idx_ext;
      base_q    <= BASE_W'(req_i.start_angle) * BASE_W'(ANGLE_SCALE);
      s1_meta_q <= s1_meta_d;
    end
    if (s2_ready && s1_valid_q) begin
      x_q       <= x_wrap;
      s2_meta_q <= s1_meta_q;
    end
    if (out_ready && s2_valid_q) begin
      angle_q    <= y_scaled[FRAC_SHIFT +: ANGLE_W];
      out_meta_q <= s2_meta_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign angle_centideg_o    = angle_q;
  assign distance_o          = out_meta_q.distance;
  assign slot_index_o        = out_meta_q.slot_index;
  assign beyond_store_o      = out_meta_q.beyond_store;
  assign last_of_frame_o     = out_meta_q.last_of_frame;
  assign end_of_revolution_o = out_meta_q.end_of_revolution;

  `ASSERT_RST(a_base_bound, slot_base_q < SbW'(RevPoints), "slot base past revolution")
  `ASSERT_RST(a_eor_last, (out_valid_o && end_of_revolution_o) |-> last_of_frame_o,
              "revolution end off frame end")
  `ASSERT_RST(a_base_clear, (pop_o && eor) |=> (slot_base_q == '0),
              "slot base not cleared at revolution end")

endmodule

@@ hw/rtl/lidar_frame_point_decoder_top.sv @@
// Scan-frame point decoder: takes frame bytes one per request (frame_start_i marks byte 0),
// reads the start angle from bytes 2 and 3 and, on the high distance byte of each sample,
// produces one point with interpolated angle in centidegrees, raw distance and its slot
// in the revolution. One byte is accepted every cycle while in_stall_o is low, and
// in_stall_o rises only when the two-entry point queue between the byte parser and the
// point pipeline is full, which happens only under a stalled output since a frame yields
// at most one point per four bytes. After its high distance byte is accepted, a point
// passes through the queue, the multiply stage, the wrap stage and the scale/output
// register, and the pipeline delivers one point per cycle while out_stall_i is low.
`include "assert_macros.svh"

module lidar_frame_point_decoder_top #(
  parameter int unsigned POINTS_PER_FRAME = lfpd_pkg::POINTS_PER_FRAME_DEF,
  parameter int unsigned REV_STORE_POINTS = lfpd_pkg::REV_STORE_POINTS_DEF,
  parameter int unsigned FRAMES_PER_REV   = lfpd_pkg::FRAMES_PER_REV_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] angle_centideg_o,
  output logic [15:0] distance_o,
  output logic [8:0]  slot_index_o,
  output logic        beyond_store_o,
  output logic        last_of_frame_o,
  output logic        end_of_revolution_o
);
  import lfpd_pkg::*;

  logic       push, q_full, q_valid, pop;
  point_req_t push_req, head_req;

  lfpd_front #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .frame_start_i(frame_start_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .req_o        (push_req)
  );

  lfpd_queue #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH($bits(point_req_t))
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_req),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .data_o (head_req)
  );

  lfpd_back #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .REV_STORE_POINTS(REV_STORE_POINTS),
    .FRAMES_PER_REV  (FRAMES_PER_REV)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .req_i              (head_req),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .angle_centideg_o   (angle_centideg_o),
    .distance_o         (distance_o),
    .slot_index_o       (slot_index_o),
    .beyond_store_o     (beyond_store_o),
    .last_of_frame_o    (last_of_frame_o),
    .end_of_revolution_o(end_of_revolution_o)
  );

  `ASSERT_RST(a_stall_only_full, in_stall_o |-> q_full, "input stalled with queue room")
  `ASSERT_RST(a_full_needs_backlog, q_full |-> q_valid, "full queue reports empty")
  `ASSERT_RST(a_pop_has_entry, pop |-> q_valid, "pop from empty queue")

endmodule

@@ bench/lidar_frame_point_decoder_top_tb.sv @@
module lidar_frame_point_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpd_pkg::*;

  localparam int unsigned PTS_PER_FRAME = POINTS_PER_FRAME_DEF;
  localparam int unsigned FRAME_LEN     = HDR_BYTES + BYTES_PER_SAMPLE * PTS_PER_FRAME;
  localparam int unsigned REV_SLOTS     = FRAMES_PER_REV_DEF * PTS_PER_FRAME;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned MAX_PRINTS    = 100;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  typedef struct packed {
    logic [ANGLE_W-1:0]    angle;
    logic [DIST_W-1:0]     distance;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  beyond;
    logic                  last;
    logic                  rev_end;
  } point_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i     = 8'h00;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [15:0] angle_centideg_o;
  logic [15:0] distance_o;
  logic [8:0]  slot_index_o;
  logic        beyond_store_o;
  logic        last_of_frame_o;
  logic        end_of_revolution_o;

  // Decoder state mirrored by the predictor
  int unsigned      byte_pos;
  logic [14:0]      prev_angle;
  logic [14:0]      cur_angle;
  logic [15:0]      step_num;
  logic [7:0]       dist_lo;
  int unsigned      slot_base;

  point_t           pending_points[$];
  int unsigned      mismatch_count;
  int unsigned      revolutions_done;
  int unsigned      cycle_count;
  int unsigned      burst_left;
  bit               valid_held;
  stall_mode_e      stall_mode;
  int unsigned      stall_run;

  lidar_frame_point_decoder_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .rx_byte_i           (rx_byte_i),
    .frame_start_i       (frame_start_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .angle_centideg_o    (angle_centideg_o),
    .distance_o          (distance_o),
    .slot_index_o        (slot_index_o),
    .beyond_store_o      (beyond_store_o),
    .last_of_frame_o     (last_of_frame_o),
    .end_of_revolution_o (end_of_revolution_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: runs of no stall, light, heavy and toggling
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run  = $urandom_range(10, 80);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ~out_stall_i;
    endcase
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Interpolated angle in centidegrees; x held in 1/1280 degree
  function automatic logic [15:0] centideg_of(input logic [14:0] start,
                                               input logic [15:0] step,
                                               input int unsigned idx);
    longint x;
    longint q;
    x = longint'(start) * ANGLE_SCALE + longint'($signed(step)) * longint'(idx);
    if (x > longint'(FULL_TURN_FINE)) x -= longint'(FULL_TURN_FINE);
    // arithmetic shift floors toward minus infinity
    q = (x * 5) >>> FRAC_SHIFT;
    return q[15:0];
  endfunction

  // Advance the mirrored state by one accepted byte, queue any point it yields
  task automatic track_frame_byte(input logic [7:0] b, input logic fs);
    int unsigned pos;
    int unsigned k;
    int unsigned idx;
    int unsigned slot;
    int unsigned nb;
    int          diff;
    logic [14:0] nw;
    point_t      pt;
    pos = fs ? 0 : byte_pos;
    byte_pos = (pos < FRAME_LEN) ? pos + 1 : FRAME_LEN;
    if (pos == ANGLE_LO_POS) begin
      cur_angle = {7'd0, b};
    end else if (pos == ANGLE_HI_POS) begin
      nw = {b[6:0], cur_angle[7:0]};
      // no forward progress means a full turn has passed
      if (nw > prev_angle) diff = int'(nw) - int'(prev_angle);
      else diff = int'(nw) + int'(FULL_TURN_COARSE) - int'(prev_angle);
      step_num   = diff[15:0];
      prev_angle = nw;
      cur_angle  = nw;
    end else if (pos >= HDR_BYTES && pos < FRAME_LEN) begin
      k   = pos - HDR_BYTES;
      idx = k >> SAMPLE_SHIFT;
      if (k[1:0] == DIST_LO_OFS) begin
        dist_lo = b;
      end else if (k[1:0] == DIST_HI_OFS) begin
        slot       = slot_base + idx;
        pt.angle   = centideg_of(cur_angle, step_num, idx);
        pt.distance = {b, dist_lo};
        pt.slot    = slot[8:0];
        pt.beyond  = (slot >= REV_STORE_POINTS_DEF);
        pt.last    = (idx == PTS_PER_FRAME - 1);
        pt.rev_end = 1'b0;
        if (pt.last) begin
          nb = slot_base + PTS_PER_FRAME;
          pt.rev_end = (nb >= REV_SLOTS);
          slot_base = pt.rev_end ? 0 : nb;
          if (pt.rev_end) revolutions_done++;
        end
        pending_points.push_back(pt);
      end
    end
  endtask

  // One byte request; returns in the step where it was accepted or after a gap
  task automatic send_byte(input logic [7:0] b, input logic fs);
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= fs;
    valid_held = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    track_frame_byte(b, fs);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Output check against the oldest expected point
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_points.size() == 0) begin
        report_mismatch("point with nothing pending, distance", distance_o, 0);
      end else begin
        want = pending_points.pop_front();
        if (angle_centideg_o !== want.angle)
          report_mismatch("angle_centideg", angle_centideg_o, want.angle);
        if (distance_o !== want.distance)
          report_mismatch("distance", distance_o, want.distance);
        if (slot_index_o !== want.slot)
          report_mismatch("slot_index", slot_index_o, want.slot);
        if (beyond_store_o !== want.beyond)
          report_mismatch("beyond_store", beyond_store_o, want.beyond);
        if (last_of_frame_o !== want.last)
          report_mismatch("last_of_frame", last_of_frame_o, want.last);
        if (end_of_revolution_o !== want.rev_end)
          report_mismatch("end_of_revolution", end_of_revolution_o, want.rev_end);
      end
    end
  end

  // No frame marker after reset; angle at its top value, so the fine angle wraps
  task automatic test_start_without_marker();
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Backward angle gives a negative step; frames cut short; equal angle is a full turn
  task automatic test_angle_wrap_and_cut();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Mostly whole frames with random content and a turning heading, some cut
  // short or overrun, and some loose noise
  task automatic test_random_traffic();
    int unsigned counted;
    int unsigned pick;
    int unsigned len;
    int unsigned heading;
    logic [7:0]  b;
    counted = 0;
    heading = $urandom_range(0, FULL_TURN_COARSE - 1);
    while (counted < RANDOM_ITEMS || revolutions_done == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 92) begin
        len = (pick < 80) ? FRAME_LEN : $urandom_range(1, FRAME_LEN - 1);
        pick = $urandom_range(0, 99);
        if (pick < 70)
          heading = (heading + $urandom_range(1400, 1900)) % FULL_TURN_COARSE;
        else if (pick < 85)
          heading = $urandom_range(0, 32767);
        else if (pick < 92)
          heading = (heading >= 300) ? heading - $urandom_range(0, 300) : heading;
        else
          heading = ($urandom_range(0, 1) == 0) ? 0 : 32767;
        for (int unsigned p = 0; p < len; p++) begin
          if (p == ANGLE_LO_POS) b = heading[7:0];
          else if (p == ANGLE_HI_POS) b = {1'($urandom_range(0, 1)), heading[14:8]};
          else b = 8'($urandom_range(0, 255));
          send_byte(b, p == 0);
          counted++;
        end
        // bytes past the end of a whole frame are dropped by the block
        if (len == FRAME_LEN && $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          counted++;
        end
      end
    end
  endtask

  initial begin
    byte_pos         = 0;
    prev_angle       = '0;
    cur_angle        = '0;
    step_num         = '0;
    dist_lo          = '0;
    slot_base        = 0;
    mismatch_count   = 0;
    revolutions_done = 0;
    cycle_count      = 0;
    burst_left       = 0;
    valid_held       = 1'b0;
    stall_mode       = STALL_NONE;
    stall_run        = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_start_without_marker();
    test_angle_wrap_and_cut();
    test_random_traffic();

    if (valid_held) in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ lidar_frame_point_decoder_top.f @@
+incdir+hw/rtl
hw/rtl/lfpd_pkg.sv
hw/rtl/lfpd_front.sv
hw/rtl/lfpd_queue.sv
hw/rtl/lfpd_back.sv
hw/rtl/lidar_frame_point_decoder_top.sv
bench/lidar_frame_point_decoder_top_tb.sv
